### rtl/puncd_pkg.sv
// ----------------------------------------------------------------------------
// puncd_pkg
// Widths and register indexes shared by the permutation unrank block.
// ----------------------------------------------------------------------------
package puncd_pkg;

	// field widths
	localparam int POS_W   = 3;
	localparam int CNT_W   = 3;
	localparam int RANK_W  = 10;
	localparam int DEG_W   = 4;
	localparam int IDX_W   = 3;
	localparam int DIGIT_W = 3;

	// stream widths, padded to whole bytes
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 8;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERM_RANK     = 1'd1;

	localparam logic [CNT_W-1:0]  ELEMENT_COUNT_RST = 3'd4;
	localparam logic [RANK_W-1:0] PERM_RANK_RST     = 10'd0;

	// reciprocal scaling for division by small constants
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = RANK_W + RECIP_SHIFT;

	// degrees below this value get one added
	localparam logic [DEG_W-1:0] DEG_ODD_LIMIT = 4'd7;

endpackage

### rtl/permutation_unrank_chord_degree.sv
// ----------------------------------------------------------------------------
// permutation_unrank_chord_degree
// Pipelined lexicographic permutation unrank with chord degree mapping.
// ----------------------------------------------------------------------------
// Usage:
//   The configuration port sets element_count (index 0) and perm_rank
//   (index 1); the rank is used modulo element_count factorial. Each request
//   on the s_ side carries a position; the block answers with the element
//   of the unranked permutation at that position, mapped to a chord degree
//   (2k+1 below 7, else 2k) on m_tdata, and position_error on m_tuser.
//   An out of range position gives degree 0 with the error flag set.
// Throughput and stages:
//   One request per cycle while m_tready allows. Each factorial-base digit
//   takes three stages: reciprocal multiply, remainder correction, and
//   insertion into the index list.
// Reset and stall:
//   Reset empties the pipeline and loads element_count 4 and perm_rank 0.
//   Each stage holds its request while the next one is full and stalled,
//   so bubbles close up and nothing is lost or repeated under back pressure.
// ----------------------------------------------------------------------------
module permutation_unrank_chord_degree #(
	parameter int MAX_ELEMENTS = 6
) (
	input  logic clk,
	input  logic arst_n,

	// configuration write port
	input  logic                                cfg_we,
	input  logic [puncd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [puncd_pkg::CFG_DATA_W-1:0]    cfg_data,

	// request stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [puncd_pkg::S_TDATA_W-1:0]     s_tdata,   // [2:0] position

	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [puncd_pkg::M_TDATA_W-1:0]     m_tdata,   // [3:0] chord_degree
	output logic                                m_tuser    // [0] position_error
);

	localparam int NUM_DIGITS = MAX_ELEMENTS - 1;
	localparam int NUM_REC    = 3 * NUM_DIGITS + 1;
	localparam int SEL_W      = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	typedef struct packed {
		logic [puncd_pkg::POS_W-1:0]                         pos;
		logic [puncd_pkg::CNT_W-1:0]                         n;
		logic [puncd_pkg::RANK_W-1:0]                        q;
		logic [puncd_pkg::RANK_W-1:0]                        qe;
		logic [puncd_pkg::DIGIT_W-1:0]                       d;
		logic [MAX_ELEMENTS-1:0][puncd_pkg::IDX_W-1:0]       a;
	} rec_t;

	logic [puncd_pkg::CNT_W-1:0]  element_count_q;
	logic [puncd_pkg::RANK_W-1:0] perm_rank_q;

	rec_t             rec_s [NUM_REC];
	logic [NUM_REC-1:0] vld_s;
	logic [NUM_REC:0]   rdy;

	logic                             out_vld_s;
	logic [puncd_pkg::DEG_W-1:0]      out_deg_s;
	logic                             out_err_s;

	logic [puncd_pkg::CNT_W-1:0]      n_clamp;
	rec_t                             rec_entry;

	logic                             last_err;
	logic [puncd_pkg::CNT_W-1:0]      last_sel;
	logic [puncd_pkg::IDX_W-1:0]      last_idx;
	logic [puncd_pkg::DEG_W-1:0]      last_deg;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= puncd_pkg::ELEMENT_COUNT_RST;
			perm_rank_q     <= puncd_pkg::PERM_RANK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				puncd_pkg::REG_ELEMENT_COUNT: begin
					element_count_q <= cfg_data[puncd_pkg::CNT_W-1:0];
				end
				puncd_pkg::REG_PERM_RANK: begin
					perm_rank_q <= cfg_data[puncd_pkg::RANK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ready chain, a stage loads when empty or when its successor loads
	assign rdy[NUM_REC] = !out_vld_s || m_tready;

	genvar k;
	generate
		for (k = 0; k < NUM_REC; k++) begin : g_rdy
			assign rdy[k] = !vld_s[k] || rdy[k+1];
		end
	endgenerate

	assign s_tready = rdy[0];

	// entry stage: clamp the element count, start with an all-zero index list
	always_comb begin
		if (element_count_q == '0) begin
			n_clamp = puncd_pkg::CNT_W'(1);
		end else if ({1'b0, element_count_q} > (puncd_pkg::CNT_W + 1)'(MAX_ELEMENTS)) begin
			n_clamp = puncd_pkg::CNT_W'(MAX_ELEMENTS);
		end else begin
			n_clamp = element_count_q;
		end
		rec_entry     = '0;
		rec_entry.pos = s_tdata[puncd_pkg::POS_W-1:0];
		rec_entry.n   = n_clamp;
		rec_entry.q   = perm_rank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			rec_s[0] <= rec_entry;
		end
	end

	// three stages per factorial-base digit j, divisor j+1
	genvar j;
	generate
		for (j = 1; j <= NUM_DIGITS; j++) begin : g_digit
			localparam int DV     = j + 1;
			localparam int RECIP  = (1 << puncd_pkg::RECIP_SHIFT) / DV;
			localparam int K_MUL  = 3 * j - 2;
			localparam int K_FIX  = 3 * j - 1;
			localparam int K_INS  = 3 * j;

			logic [puncd_pkg::PROD_W-1:0]   prod;
			rec_t                           mul_nxt;
			logic [puncd_pkg::RANK_W+3:0]   back;
			logic [puncd_pkg::RANK_W+3:0]   rem;
			rec_t                           fix_nxt;
			rec_t                           ins_nxt;

			// estimate of q / (j+1), low by at most one
			always_comb begin
				mul_nxt    = rec_s[K_MUL-1];
				prod       = puncd_pkg::PROD_W'(rec_s[K_MUL-1].q)
				           * puncd_pkg::PROD_W'(RECIP);
				mul_nxt.qe = prod[puncd_pkg::PROD_W-1:puncd_pkg::RECIP_SHIFT];
			end

			// remainder and one correction step give the digit and the quotient
			always_comb begin
				fix_nxt = rec_s[K_FIX-1];
				back    = (puncd_pkg::RANK_W + 4)'(rec_s[K_FIX-1].qe)
				        * (puncd_pkg::RANK_W + 4)'(DV);
				rem     = (puncd_pkg::RANK_W + 4)'(rec_s[K_FIX-1].q) - back;
				if (rem >= (puncd_pkg::RANK_W + 4)'(DV)) begin
					fix_nxt.q = rec_s[K_FIX-1].qe + puncd_pkg::RANK_W'(1);
					fix_nxt.d = puncd_pkg::DIGIT_W'(rem - (puncd_pkg::RANK_W + 4)'(DV));
				end else begin
					fix_nxt.q = rec_s[K_FIX-1].qe;
					fix_nxt.d = puncd_pkg::DIGIT_W'(rem);
				end
			end

			// insert the digit; digits at or above n are beyond n! and dropped
			always_comb begin
				ins_nxt = rec_s[K_INS-1];
				if ((puncd_pkg::CNT_W + 1)'(j) < {1'b0, rec_s[K_INS-1].n}) begin
					ins_nxt.a[j] = puncd_pkg::IDX_W'(rec_s[K_INS-1].d);
					for (int i = 0; i < j; i++) begin
						if (rec_s[K_INS-1].a[i] >= puncd_pkg::IDX_W'(rec_s[K_INS-1].d)) begin
							ins_nxt.a[i] = rec_s[K_INS-1].a[i] + puncd_pkg::IDX_W'(1);
						end
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[K_MUL] <= 1'b0;
					vld_s[K_FIX] <= 1'b0;
					vld_s[K_INS] <= 1'b0;
				end else begin
					if (rdy[K_MUL]) begin
						vld_s[K_MUL] <= vld_s[K_MUL-1];
					end
					if (rdy[K_FIX]) begin
						vld_s[K_FIX] <= vld_s[K_FIX-1];
					end
					if (rdy[K_INS]) begin
						vld_s[K_INS] <= vld_s[K_INS-1];
					end
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[K_MUL]) begin
					rec_s[K_MUL] <= mul_nxt;
				end
				if (rdy[K_FIX]) begin
					rec_s[K_FIX] <= fix_nxt;
				end
				if (rdy[K_INS]) begin
					rec_s[K_INS] <= ins_nxt;
				end
			end
		end
	endgenerate

	// output stage: pick the index at the position, map it to a degree
	always_comb begin
		last_err = {1'b0, rec_s[NUM_REC-1].pos} >= {1'b0, rec_s[NUM_REC-1].n};
		last_sel = rec_s[NUM_REC-1].n - puncd_pkg::CNT_W'(1) - rec_s[NUM_REC-1].pos;
		last_idx = rec_s[NUM_REC-1].a[last_sel[SEL_W-1:0]];
		last_deg = {last_idx, 1'b0};
		if (last_deg < puncd_pkg::DEG_ODD_LIMIT) begin
			last_deg = last_deg + puncd_pkg::DEG_W'(1);
		end
		if (last_err) begin
			last_deg = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s <= 1'b0;
		end else if (rdy[NUM_REC]) begin
			out_vld_s <= vld_s[NUM_REC-1];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NUM_REC]) begin
			out_deg_s <= last_deg;
			out_err_s <= last_err;
		end
	end

	assign m_tvalid = out_vld_s;
	assign m_tdata  = puncd_pkg::M_TDATA_W'(out_deg_s);
	assign m_tuser  = out_err_s;

endmodule
